// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the primality tester. Each macro
// samples on clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TDP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tdp_pkg.sv =====
// ----------------------------------------------------------------------------
// tdp_pkg
// Types and constants shared by the trial division primality tester.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdp_pkg;

    localparam int CAND_W        = 32;
    localparam int ECHO_W        = 32;
    localparam int FIRST_DIVISOR = 2;
    localparam int DIVISOR_STEP  = 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } tdp_state_t;

endpackage

// ===== sv/tdp_cand_if.sv =====
// ----------------------------------------------------------------------------
// tdp_cand_if
// Valid/ready channel that carries one candidate integer per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tdp_cand_if;

    logic                        valid;
    logic                        ready;
    logic [tdp_pkg::CAND_W-1:0]  candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);

endinterface

// ===== sv/tdp_result_if.sv =====
// ----------------------------------------------------------------------------
// tdp_result_if
// Valid/ready channel that carries the tested value and its primality flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tdp_result_if;

    logic                        valid;
    logic                        ready;
    logic [tdp_pkg::ECHO_W-1:0]  tested_value;
    logic                        is_prime;

    modport source (output valid, output tested_value, output is_prime, input ready);
    modport sink   (input valid, input tested_value, input is_prime, output ready);

endinterface

// ===== sv/tdp_div_serial.sv =====
// ----------------------------------------------------------------------------
// tdp_div_serial
// Restoring divider that retires one quotient bit per cycle, dividend MSB
// first, and reports quotient and remainder with a one-cycle done pulse.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdp_div_serial #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    cnt_next;
    logic             done_reg;
    logic             done_next;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] quo_next;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] rem_next;
    logic [WIDTH-1:0] dsr_reg;
    logic [WIDTH-1:0] dsr_next;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;

    assign trial = {rem_reg, quo_reg[WIDTH-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            cnt_next = CW'(WIDTH);
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - CW'(1);
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = diff[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== sv/trial_division_prime_test_top.sv =====
// ----------------------------------------------------------------------------
// trial_division_prime_test_top
// Tests one unsigned candidate per request for primality by trial division
// and returns the tested value with its primality flag.
// ----------------------------------------------------------------------------
// Only the low W bits of a candidate are tested and echoed, W being VALUE_WIDTH
// capped at 32. Zero and one are reported not prime. Divisors 2, 3, 4 and so on
// are tried while the divisor does not exceed the quotient, and the test stops at
// the first one that leaves no remainder. Each trial divisor runs through the
// bit-serial divider. A prime n runs floor(sqrt(n)) divisions. When the test
// ends, the tester passes through the finish state, which loads the result into
// the output register once that register is free or being read, and then
// returns to idle, where the next request can be taken. Zero and one go
// straight from idle to the finish state without a division. One candidate is
// worked on at a time, and a finished result sits in an output register, so the
// next request is taken while that result waits on the result channel.
`timescale 1ns / 1ps

module trial_division_prime_test_top #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    tdp_cand_if.sink     candidates,
    tdp_result_if.source results
);

    localparam int NW = (VALUE_WIDTH < tdp_pkg::CAND_W) ? VALUE_WIDTH : tdp_pkg::CAND_W;

    tdp_pkg::tdp_state_t         state_reg;
    tdp_pkg::tdp_state_t         state_next;
    logic [NW-1:0]               n_reg;
    logic [NW-1:0]               n_next;
    logic [NW-1:0]               d_reg;
    logic [NW-1:0]               d_next;
    logic                        prime_reg;
    logic                        prime_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [tdp_pkg::ECHO_W-1:0]  out_value_reg;
    logic [tdp_pkg::ECHO_W-1:0]  out_value_next;
    logic                        out_prime_reg;
    logic                        out_prime_next;
    logic [NW-1:0]               n_in;
    logic                        div_start;
    logic [NW-1:0]               div_dividend;
    logic [NW-1:0]               div_divisor;
    logic                        div_done;
    logic [NW-1:0]               div_quotient;
    logic [NW-1:0]               div_remainder;

    assign n_in = candidates.candidate[NW-1:0];

    tdp_div_serial #(
        .WIDTH (NW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    always_comb
    begin
        state_next       = state_reg;
        n_next           = n_reg;
        d_next           = d_reg;
        prime_next       = prime_reg;
        out_valid_next   = out_valid_reg && !results.ready;
        out_value_next   = out_value_reg;
        out_prime_next   = out_prime_reg;
        div_start        = 1'b0;
        div_dividend     = n_reg;
        div_divisor      = d_reg + NW'(tdp_pkg::DIVISOR_STEP);
        candidates.ready = 1'b0;
        unique case (state_reg)
            tdp_pkg::ST_IDLE:
            begin
                candidates.ready = 1'b1;
                div_dividend     = n_in;
                div_divisor      = NW'(tdp_pkg::FIRST_DIVISOR);
                if (candidates.valid)
                begin
                    n_next = n_in;
                    if (n_in[NW-1:1] == '0)
                    begin
                        prime_next = 1'b0;
                        state_next = tdp_pkg::ST_FINISH;
                    end
                    else
                    begin
                        d_next     = NW'(tdp_pkg::FIRST_DIVISOR);
                        div_start  = 1'b1;
                        state_next = tdp_pkg::ST_DIVIDE;
                    end
                end
            end
            tdp_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    if (d_reg > div_quotient)
                    begin
                        prime_next = 1'b1;
                        state_next = tdp_pkg::ST_FINISH;
                    end
                    else if (div_remainder == '0)
                    begin
                        prime_next = 1'b0;
                        state_next = tdp_pkg::ST_FINISH;
                    end
                    else
                    begin
                        d_next    = d_reg + NW'(tdp_pkg::DIVISOR_STEP);
                        div_start = 1'b1;
                    end
                end
            end
            tdp_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = tdp_pkg::ECHO_W'(n_reg);
                    out_prime_next = prime_reg;
                    state_next     = tdp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tdp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tdp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        d_reg         <= d_next;
        prime_reg     <= prime_next;
        out_value_reg <= out_value_next;
        out_prime_reg <= out_prime_next;
    end

    assign results.valid        = out_valid_reg;
    assign results.tested_value = out_value_reg;
    assign results.is_prime     = out_prime_reg;

endmodule

// ===== sv/tdp_checker.sv =====
// ----------------------------------------------------------------------------
// tdp_checker
// Port-level checks of the primality tester, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tdp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cand_valid,
    input logic                        cand_ready,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic [tdp_pkg::ECHO_W-1:0]  res_value,
    input logic                        res_prime
);

    `TDP_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_value) && $stable(res_prime), "Stalled result changed.")
    `TDP_ASSERT_SAME(a_small_not_prime, res_valid && res_value[tdp_pkg::ECHO_W-1:1] == '0, !res_prime, "Zero or one reported prime.")
    `TDP_ASSERT_SAME(a_even_not_prime, res_valid && !res_value[0] && res_value != tdp_pkg::ECHO_W'(2), !res_prime, "Even value above two reported prime.")
    `TDP_ASSERT_NEXT(a_busy_after_req, cand_valid && cand_ready, !cand_ready, "Request taken while a test is running.")

endmodule

bind trial_division_prime_test_top tdp_checker u_tdp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cand_valid (candidates.valid),
    .cand_ready (candidates.ready),
    .res_valid  (results.valid),
    .res_ready  (results.ready),
    .res_value  (results.tested_value),
    .res_prime  (results.is_prime)
);
